[rtl/set_assoc_lru_tag_lookup_assert.svh]
// Assertion macros for the tag lookup block.
// Define NO_ASSERTIONS to compile them out.
`ifndef SET_ASSOC_LRU_TAG_LOOKUP_ASSERT_SVH
`define SET_ASSOC_LRU_TAG_LOOKUP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that a condition implies another condition in the same cycle.
`define SALT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("salt: same-cycle check failed");

// Check that a condition implies another condition in the next cycle.
`define SALT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("salt: next-cycle check failed");

`else

`define SALT_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SALT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/salt_pkg.sv]
package salt_pkg;

    // Fixed widths of the word fields
    localparam int SET_IDX_W = 6;
    localparam int TAG_W     = 20;
    localparam int KIND_W    = 2;
    localparam int WAY_OUT_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT      = 2'd0,
        KIND_COLD     = 2'd1,
        KIND_CONFLICT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

[rtl/salt_if.sv]
interface salt_req_if;
    logic                          valid;
    logic                          ready;
    logic [salt_pkg::SET_IDX_W-1:0] set_index;
    logic [salt_pkg::TAG_W-1:0]     tag;

    modport source (output valid, output set_index, output tag, input ready);
    modport sink   (input valid, input set_index, input tag, output ready);
endinterface

interface salt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [salt_pkg::KIND_W-1:0]    access_kind;
    logic [salt_pkg::WAY_OUT_W-1:0] way;

    modport source (output valid, output access_kind, output way, input ready);
    modport sink   (input valid, input access_kind, input way, output ready);
endinterface

[rtl/set_assoc_lru_tag_lookup.sv]
// Each word does a read-modify-write of its set's tag row and state row: on accept
//   the rows are read into registers, then, once the output register is free, the
//   compute-and-write step loads the result there. Only then is a new word taken.
// Reset (synchronous, active low) starts a clearing pass that writes every
//   state row (all ways invalid, rank equal to way number); no word is
//   accepted until it ends. The tag memory is not cleared.
module set_assoc_lru_tag_lookup #(
    parameter int SETS     = 64,
    parameter int WAYS     = 4,
    parameter int TAG_BITS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    salt_req_if.sink   i_req,
    salt_rsp_if.source o_rsp
);
    import salt_pkg::*;

    `include "set_assoc_lru_tag_lookup_assert.svh"

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W = WAY_W;
    // Tags are masked to TAG_BITS (at most TAG_W), so only this many input bits matter
    localparam int KEY_W  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int META_W = WAYS + WAYS * RANK_W;
    localparam int IDX_N  = 1 << SET_IDX_W;

    // Fold the input set index into range: a small constant table
    logic [SET_W-1:0] set_lut [IDX_N];
    for (genvar g = 0; g < IDX_N; g++) begin : g_set_lut
        assign set_lut[g] = SET_W'(g % SETS);
    end

    // Memories: one tag row and one state row (valid bits, ranks) per set
    logic [WAYS-1:0][KEY_W-1:0] tag_mem  [SETS];
    logic [META_W-1:0]          meta_mem [SETS];

    t_state r_state, n_state;
    logic [SET_W-1:0] r_clr_idx;
    logic [SET_W-1:0] r_set;
    logic [KEY_W-1:0] r_key;
    logic [WAYS-1:0][KEY_W-1:0] r_tag_rd;
    logic [META_W-1:0]          r_meta_rd;

    logic              r_out_valid;
    t_kind             r_kind;
    logic [WAY_W-1:0]  r_way;

    // Control decoded from the state
    logic req_ready;
    logic mem_re;
    logic finish;
    logic clr_we;
    logic clr_last;
    logic out_free;

    // Lookup datapath
    logic [SET_W-1:0]            rd_set;
    logic [WAYS-1:0]             rd_valid;
    logic [WAYS-1:0][RANK_W-1:0] rd_rank;
    logic [WAYS-1:0]             hit_vec;
    logic [WAYS-1:0]             hit_win;
    logic [WAYS-1:0]             free_win;
    logic [WAYS-1:0]             lru_vec;
    logic [WAYS-1:0]             sel_vec;
    logic                        any_hit;
    logic                        any_free;
    t_kind                       kind;
    logic [WAY_W-1:0]            sel_idx;
    logic [RANK_W-1:0]           old_rank;
    logic [WAYS-1:0][RANK_W-1:0] new_rank;
    logic [WAYS-1:0][RANK_W-1:0] clr_rank;
    logic [WAYS-1:0][KEY_W-1:0]  new_tags;
    logic [META_W-1:0]           meta_wdata;
    logic [SET_W-1:0]            meta_waddr;
    logic                        meta_we;

    assign rd_set   = set_lut[i_req.set_index];
    assign out_free = !r_out_valid || o_rsp.ready;
    assign clr_last = (r_clr_idx == SET_W'(SETS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req.valid) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        req_ready = 1'b0;
        finish    = 1'b0;
        clr_we    = 1'b0;
        case (r_state)
            ST_CLEAR:  clr_we    = 1'b1;
            ST_IDLE:   req_ready = 1'b1;
            ST_LOOKUP: finish    = out_free;
            default: begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign mem_re      = req_ready && i_req.valid;
    assign i_req.ready = req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (clr_we) r_clr_idx <= r_clr_idx + SET_W'(1);
        end
    end

    // Hold the accessed set and masked tag for the write-back
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_set <= rd_set;
            r_key <= i_req.tag[KEY_W-1:0];
        end
    end

    // Tag memory: read on accept, write the whole row back on finish
    always_ff @(posedge i_clk) begin
        if (finish) tag_mem[r_set] <= new_tags;
        if (mem_re) r_tag_rd <= tag_mem[rd_set];
    end

    // State memory: written by the clearing pass or by the write-back
    always_ff @(posedge i_clk) begin
        if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
        if (mem_re)  r_meta_rd <= meta_mem[rd_set];
    end

    assign rd_valid = r_meta_rd[META_W-1 -: WAYS];
    assign rd_rank  = r_meta_rd[WAYS*RANK_W-1:0];

    // Compare every way of the set at once
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = rd_valid[w] && (r_tag_rd[w] == r_key);
            lru_vec[w] = (rd_rank[w] == RANK_W'(WAYS - 1));
        end
    end

    // Among candidates take the way of lowest rank: a way wins when no
    // other candidate is more recent
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hit_win[w]  = hit_vec[w];
            free_win[w] = !rd_valid[w];
            for (int j = 0; j < WAYS; j++) begin
                if (hit_vec[j] && (rd_rank[j] < rd_rank[w])) hit_win[w] = 1'b0;
                if (!rd_valid[j] && (rd_rank[j] < rd_rank[w])) free_win[w] = 1'b0;
            end
        end
    end

    assign any_hit  = |hit_vec;
    assign any_free = !(&rd_valid);

    always_comb begin
        if (any_hit) begin
            sel_vec = hit_win;
            kind    = KIND_HIT;
        end else if (any_free) begin
            sel_vec = free_win;
            kind    = KIND_COLD;
        end else begin
            sel_vec = lru_vec;
            kind    = KIND_CONFLICT;
        end
    end

    // Encode the one-hot choice and fetch its old rank
    always_comb begin
        sel_idx  = '0;
        old_rank = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (sel_vec[w]) begin
                sel_idx  = sel_idx | WAY_W'(w);
                old_rank = old_rank | rd_rank[w];
            end
        end
    end

    // Promote the chosen way; age every more recent way by one
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            if (sel_vec[w]) begin
                new_rank[w] = '0;
                new_tags[w] = r_key;
            end else begin
                new_rank[w] = (rd_rank[w] < old_rank) ? rd_rank[w] + RANK_W'(1)
                                                      : rd_rank[w];
                new_tags[w] = r_tag_rd[w];
            end
            clr_rank[w] = RANK_W'(w);
        end
    end

    always_comb begin
        meta_we    = clr_we || finish;
        meta_waddr = clr_we ? r_clr_idx : r_set;
        meta_wdata = clr_we ? {{WAYS{1'b0}}, clr_rank}
                            : {rd_valid | sel_vec, new_rank};
    end

    // Output register: parts the lookup from the result side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_kind <= kind;
            r_way  <= sel_idx;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.access_kind = r_kind;
    assign o_rsp.way         = WAY_OUT_W'(r_way);

    // An accepted word always moves on to the lookup cycle
    `SALT_ASSERT_NEXT(a_accept_to_lookup, i_clk, i_rst_n, mem_re, r_state == ST_LOOKUP)
    // Exactly one way is chosen whenever a lookup completes
    `SALT_ASSERT_SAME(a_sel_onehot, i_clk, i_rst_n, finish, $onehot(sel_vec))
    // A cold fill never lands on a valid way
    `SALT_ASSERT_SAME(a_cold_free, i_clk, i_rst_n, finish && kind == KIND_COLD, (sel_vec & rd_valid) == '0)
    // A new result only ever follows a completed lookup
    `SALT_ASSERT_SAME(a_result_src, i_clk, i_rst_n, $rose(o_rsp.valid), $past(finish))

endmodule
